// ----- hdl/line_follow_avoid_controller_defines.svh -----
// ---------------------------------------------------------------------------
// line_follow_avoid_controller_defines
// Assertion macros shared by the line follow / avoid controller.
// Each macro expects clk and rst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef LINE_FOLLOW_AVOID_CONTROLLER_DEFINES_SVH
`define LINE_FOLLOW_AVOID_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LFAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LFAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lfac_pkg.sv -----
// ---------------------------------------------------------------------------
// lfac_pkg
// Shared widths, mode codes and controller/datapath command types.
// ---------------------------------------------------------------------------
package lfac_pkg;

  // Port and field widths
  localparam int unsigned IN_FIELDS_W = 20;
  localparam int unsigned IN_W        = 24;
  localparam int unsigned OUT_W       = 48;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned PWM_W       = 14;
  localparam int unsigned MODE_W      = 4;
  localparam int unsigned DRIVE_W     = 13;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned GAIN_W      = 16;

  // Operating modes
  typedef enum logic [MODE_W-1:0] {
    MODE_RUN     = 4'd0,
    MODE_BLOCKED = 4'd1,
    MODE_LEFT    = 4'd3,
    MODE_RIGHT   = 4'd4,
    MODE_REALIGN = 4'd5,
    MODE_DASH    = 4'd6,
    MODE_AVOID   = 4'd7,
    MODE_RETURN  = 4'd8
  } mode_t;

  // Steering source loaded at the steer step
  typedef enum logic [2:0] {
    STEER_HOLD,
    STEER_PID,
    STEER_NEG_TURN,
    STEER_POS_TURN,
    STEER_ZERO
  } steer_sel_t;

  // Forward drive source loaded at the steer step
  typedef enum logic [2:0] {
    FWD_HOLD,
    FWD_PID,
    FWD_ZERO,
    FWD_BACK,
    FWD_DASH
  } fwd_sel_t;

  // Wheel output update
  typedef enum logic [1:0] {
    HELD_KEEP,
    HELD_MIX,
    HELD_AVOID,
    HELD_RETURN
  } held_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       pid_err;
    logic       steer_en;
    steer_sel_t steer_sel;
    fwd_sel_t   fwd_sel;
    logic       held_en;
    held_sel_t  held_sel;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic obstacle_near;
    logic line_blocked;
  } dp_stat_t;

endpackage

// ----- hdl/lfac_ctrl.sv -----
// ---------------------------------------------------------------------------
// lfac_ctrl
// Tick sequencer: mode machine, per-mode tick counters, handshakes and the
// command schedule for the datapath.
// ---------------------------------------------------------------------------
module lfac_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lfac_pkg::MODE_W-1:0] out_mode,
  input  lfac_pkg::dp_stat_t          stat,
  output lfac_pkg::dp_cmd_t           cmd
);
  import lfac_pkg::*;

  localparam logic [2:0] LEFT_TICKS    = 3'd6;
  localparam logic [3:0] RIGHT_TICKS   = 4'd12;
  localparam logic [1:0] BACKUP_TICKS  = 2'd2;
  localparam logic [2:0] REALIGN_TICKS = 3'd6;
  localparam logic [2:0] REALIGN_EXIT  = 3'd2;
  localparam logic [1:0] DASH_TICKS    = 2'd3;
  localparam logic [4:0] AVOID_TICKS   = 5'd23;
  localparam logic [3:0] RETURN_TICKS  = 4'd13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_STEER,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_OUT
  } state_t;

  state_t     state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  mode_t      handled_r, handled_nxt;
  mode_t      out_mode_r, out_mode_nxt;
  logic [2:0] left_cnt_r, left_cnt_nxt;
  logic [3:0] right_cnt_r, right_cnt_nxt;
  logic [1:0] backup_cnt_r, backup_cnt_nxt;
  logic [2:0] realign_cnt_r, realign_cnt_nxt;
  logic [1:0] dash_cnt_r, dash_cnt_nxt;
  logic [4:0] avoid_cnt_r, avoid_cnt_nxt;
  logic [3:0] return_cnt_r, return_cnt_nxt;
  steer_sel_t steer_sel_r, steer_sel_nxt;
  fwd_sel_t   fwd_sel_r, fwd_sel_nxt;
  held_sel_t  held_sel_r, held_sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       near;
  mode_t      eff_mode;
  logic       slot_free;
  logic       pid_go;

  assign slot_free = !out_valid_r || out_tready;

  // Obstacle override and per-mode decision
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    handled_nxt     = handled_r;
    out_mode_nxt    = out_mode_r;
    left_cnt_nxt    = left_cnt_r;
    right_cnt_nxt   = right_cnt_r;
    backup_cnt_nxt  = backup_cnt_r;
    realign_cnt_nxt = realign_cnt_r;
    dash_cnt_nxt    = dash_cnt_r;
    avoid_cnt_nxt   = avoid_cnt_r;
    return_cnt_nxt  = return_cnt_r;
    steer_sel_nxt   = steer_sel_r;
    fwd_sel_nxt     = fwd_sel_r;
    held_sel_nxt    = held_sel_r;
    out_valid_nxt   = out_valid_r;
    pid_go          = 1'b0;

    near     = stat.obstacle_near && (mode_r != MODE_AVOID) && (mode_r != MODE_RETURN);
    eff_mode = near ? MODE_AVOID : mode_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt     = ST_MUL;
        handled_nxt   = eff_mode;
        steer_sel_nxt = STEER_HOLD;
        fwd_sel_nxt   = FWD_HOLD;
        held_sel_nxt  = HELD_KEEP;
        mode_nxt      = MODE_RUN;
        if (near) begin
          avoid_cnt_nxt  = AVOID_TICKS;
          return_cnt_nxt = RETURN_TICKS;
        end
        case (eff_mode)
          MODE_RUN: begin
            pid_go        = 1'b1;
            steer_sel_nxt = STEER_PID;
            fwd_sel_nxt   = FWD_PID;
            mode_nxt      = stat.line_blocked ? MODE_BLOCKED : MODE_RUN;
          end
          MODE_BLOCKED: begin
            mode_nxt        = MODE_LEFT;
            left_cnt_nxt    = LEFT_TICKS;
            right_cnt_nxt   = RIGHT_TICKS;
            realign_cnt_nxt = REALIGN_TICKS;
            dash_cnt_nxt    = DASH_TICKS;
          end
          MODE_LEFT: begin
            if (left_cnt_r != '0) begin
              left_cnt_nxt   = left_cnt_r - 3'd1;
              fwd_sel_nxt    = FWD_ZERO;
              steer_sel_nxt  = STEER_NEG_TURN;
              backup_cnt_nxt = BACKUP_TICKS;
              mode_nxt       = MODE_LEFT;
            end else if (stat.line_blocked) begin
              mode_nxt = MODE_RIGHT;
            end else if (backup_cnt_r != '0) begin
              backup_cnt_nxt = backup_cnt_r - 2'd1;
              fwd_sel_nxt    = FWD_BACK;
              steer_sel_nxt  = STEER_ZERO;
              mode_nxt       = MODE_LEFT;
            end
          end
          MODE_RIGHT: begin
            if (right_cnt_r != '0) begin
              right_cnt_nxt  = right_cnt_r - 4'd1;
              fwd_sel_nxt    = FWD_ZERO;
              steer_sel_nxt  = STEER_POS_TURN;
              backup_cnt_nxt = BACKUP_TICKS;
              mode_nxt       = MODE_RIGHT;
            end else if (stat.line_blocked) begin
              mode_nxt = MODE_REALIGN;
            end else if (backup_cnt_r != '0) begin
              backup_cnt_nxt = backup_cnt_r - 2'd1;
              fwd_sel_nxt    = FWD_BACK;
              steer_sel_nxt  = STEER_ZERO;
              mode_nxt       = MODE_RIGHT;
            end
          end
          MODE_REALIGN: begin
            if (realign_cnt_r != '0) begin
              realign_cnt_nxt = realign_cnt_r - 3'd1;
              fwd_sel_nxt     = FWD_ZERO;
              steer_sel_nxt   = STEER_NEG_TURN;
              mode_nxt        = MODE_REALIGN;
            end else begin
              realign_cnt_nxt = REALIGN_EXIT;
              mode_nxt        = MODE_DASH;
            end
          end
          MODE_DASH: begin
            if (dash_cnt_r != '0) begin
              dash_cnt_nxt  = dash_cnt_r - 2'd1;
              fwd_sel_nxt   = FWD_DASH;
              steer_sel_nxt = STEER_ZERO;
              mode_nxt      = MODE_DASH;
            end
          end
          MODE_AVOID: begin
            if (near || avoid_cnt_r != '0) begin
              // a fresh obstacle reloads the counter before it is used
              avoid_cnt_nxt = (near ? AVOID_TICKS : avoid_cnt_r) - 5'd1;
              held_sel_nxt  = HELD_AVOID;
              mode_nxt      = MODE_AVOID;
            end else begin
              avoid_cnt_nxt  = AVOID_TICKS;
              return_cnt_nxt = RETURN_TICKS;
              mode_nxt       = MODE_RETURN;
            end
          end
          MODE_RETURN: begin
            if (return_cnt_r != '0) begin
              return_cnt_nxt = return_cnt_r - 4'd1;
              held_sel_nxt   = HELD_RETURN;
              mode_nxt       = MODE_RETURN;
            end else begin
              return_cnt_nxt = RETURN_TICKS;
            end
          end
          default: begin
            mode_nxt = MODE_RUN;
          end
        endcase
        // every mode outside avoidance remixes the wheels
        if (mode_nxt != MODE_AVOID && mode_nxt != MODE_RETURN) begin
          held_sel_nxt = HELD_MIX;
        end
      end
      ST_MUL:   state_nxt = ST_STEER;
      ST_STEER: state_nxt = ST_W1;
      ST_W1:    state_nxt = ST_W2;
      ST_W2:    state_nxt = ST_W3;
      ST_W3:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (slot_free) begin
          state_nxt    = ST_IDLE;
          out_mode_nxt = handled_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // result register handshake
    if (state_r == ST_OUT && slot_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MODE_RUN;
      handled_r     <= MODE_RUN;
      out_mode_r    <= MODE_RUN;
      left_cnt_r    <= LEFT_TICKS;
      right_cnt_r   <= RIGHT_TICKS;
      backup_cnt_r  <= BACKUP_TICKS;
      realign_cnt_r <= REALIGN_TICKS;
      dash_cnt_r    <= DASH_TICKS;
      avoid_cnt_r   <= AVOID_TICKS;
      return_cnt_r  <= RETURN_TICKS;
      steer_sel_r   <= STEER_HOLD;
      fwd_sel_r     <= FWD_HOLD;
      held_sel_r    <= HELD_KEEP;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      handled_r     <= handled_nxt;
      out_mode_r    <= out_mode_nxt;
      left_cnt_r    <= left_cnt_nxt;
      right_cnt_r   <= right_cnt_nxt;
      backup_cnt_r  <= backup_cnt_nxt;
      realign_cnt_r <= realign_cnt_nxt;
      dash_cnt_r    <= dash_cnt_nxt;
      avoid_cnt_r   <= avoid_cnt_nxt;
      return_cnt_r  <= return_cnt_nxt;
      steer_sel_r   <= steer_sel_nxt;
      fwd_sel_r     <= fwd_sel_nxt;
      held_sel_r    <= held_sel_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Handshakes and datapath commands
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_mode   = out_mode_r;

  always_comb begin
    cmd.capture   = in_tvalid && (state_r == ST_IDLE);
    cmd.pid_err   = pid_go;
    cmd.steer_en  = (state_r == ST_STEER);
    cmd.steer_sel = steer_sel_r;
    cmd.fwd_sel   = fwd_sel_r;
    cmd.held_en   = (state_r == ST_OUT) && slot_free;
    cmd.held_sel  = held_sel_r;
  end

endmodule

// ----- hdl/lfac_dp.sv -----
// ---------------------------------------------------------------------------
// lfac_dp
// Datapath: configuration registers, line error and integral, PID products,
// steer/forward registers and the wheel mixing pipeline with saturation.
// ---------------------------------------------------------------------------
module lfac_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lfac_pkg::dp_cmd_t                    cmd,
  output lfac_pkg::dp_stat_t                   stat,
  input  logic [lfac_pkg::IN_FIELDS_W-1:0]     in_fields,
  input  logic                                 cfg_we,
  input  logic [lfac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfac_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [lfac_pkg::PWM_W-1:0]    pwm_left,
  output logic signed [lfac_pkg::PWM_W-1:0]    pwm_right,
  output logic signed [lfac_pkg::PWM_W-1:0]    pwm_back
);
  import lfac_pkg::*;

  localparam int unsigned ERR_W   = 6;
  localparam int unsigned DIFF_W  = 7;
  localparam int unsigned SUM_W   = 15;
  localparam int unsigned STEER_W = 32;
  localparam int unsigned FX10_W  = 18;
  localparam int unsigned MIX_W   = STEER_W + 2;
  localparam int unsigned ABS_W   = MIX_W - 1;
  localparam int unsigned P_W     = STEER_W + 5;
  localparam int unsigned QL_W    = 17;
  localparam int unsigned QB_W    = 18;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP, CFG_KI, CFG_KD, CFG_OBSTACLE, CFG_CRUISE, CFG_DASH, CFG_TURN, CFG_LIMIT
  } cfg_idx_t;

  localparam logic signed [GAIN_W-1:0] KP_RST       = 16'sd500;
  localparam logic [DIST_W-1:0]        OBSTACLE_RST = 16'd9;
  localparam logic [DRIVE_W-1:0]       CRUISE_RST   = 13'd800;
  localparam logic [DRIVE_W-1:0]       DASH_RST     = 13'd1000;
  localparam logic [DRIVE_W-1:0]       TURN_RST     = 13'd800;
  localparam logic [DRIVE_W-1:0]       LIMIT_RST    = 13'd6000;
  localparam logic [DIST_W-1:0]        NO_READING   = 16'd1;

  localparam logic signed [ERR_W-1:0]  W_OUTER   = 6'sd19;
  localparam logic signed [ERR_W-1:0]  W_INNER   = 6'sd12;
  localparam logic signed [SUM_W:0]    SUM_LIMIT = 16'sd10000;
  // outer sensor alone on the line: error forced to zero
  localparam logic [3:0] OUTER_RIGHT_ALONE = 4'b0111;
  localparam logic [3:0] OUTER_LEFT_ALONE  = 4'b1110;

  // x/10 = (x * 52429) >> 19 for x below 2^18
  localparam logic [16:0] RECIP_10       = 17'd52429;
  localparam int unsigned RECIP_10_SHIFT = 19;
  // x/25 = (x * 335545) >> 23 for x below 493447
  localparam logic [18:0] RECIP_25       = 19'd335545;
  localparam int unsigned RECIP_25_SHIFT = 23;
  // back = steer * 23 / 200
  localparam logic [4:0]  BACK_NUM       = 5'd23;

  // Configuration registers
  logic signed [GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [DIST_W-1:0]        obst_r;
  logic [DRIVE_W-1:0]       cruise_r, dash_r, turn_r, lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= KP_RST;
      ki_r     <= '0;
      kd_r     <= '0;
      obst_r   <= OBSTACLE_RST;
      cruise_r <= CRUISE_RST;
      dash_r   <= DASH_RST;
      turn_r   <= TURN_RST;
      lim_r    <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KP:       kp_r     <= $signed(cfg_data);
        CFG_KI:       ki_r     <= $signed(cfg_data);
        CFG_KD:       kd_r     <= $signed(cfg_data);
        CFG_OBSTACLE: obst_r   <= cfg_data;
        CFG_CRUISE:   cruise_r <= cfg_data[DRIVE_W-1:0];
        CFG_DASH:     dash_r   <= cfg_data[DRIVE_W-1:0];
        CFG_TURN:     turn_r   <= cfg_data[DRIVE_W-1:0];
        CFG_LIMIT:    lim_r    <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture
  logic [3:0]        sens_r;
  logic [DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sens_r <= in_fields[3:0];
      dist_r <= in_fields[IN_FIELDS_W-1:4];
    end
  end

  assign stat.obstacle_near = (dist_r <= obst_r) && (dist_r != NO_READING);
  assign stat.line_blocked  = &sens_r;

  // Line error in tenths; a raw 0 means the sensor sees the line
  logic signed [ERR_W-1:0]  err_w;
  logic signed [SUM_W:0]    sum_tmp, sum_clamped;
  logic signed [ERR_W-1:0]  err_r, last_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DIFF_W-1:0] diff_r;

  always_comb begin
    err_w = (sens_r[0] ? '0 : -W_OUTER) + (sens_r[1] ? '0 : -W_INNER)
          + (sens_r[2] ? '0 : W_INNER)  + (sens_r[3] ? '0 : W_OUTER);
    if (sens_r == OUTER_RIGHT_ALONE || sens_r == OUTER_LEFT_ALONE) begin
      err_w = '0;
    end
    sum_tmp = (SUM_W+1)'(sum_r) + (SUM_W+1)'(err_w);
    if (sum_tmp > SUM_LIMIT) begin
      sum_clamped = SUM_LIMIT;
    end else if (sum_tmp < -SUM_LIMIT) begin
      sum_clamped = -SUM_LIMIT;
    end else begin
      sum_clamped = sum_tmp;
    end
  end

  // Integral and derivative state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      last_r <= '0;
    end else if (cmd.pid_err) begin
      sum_r  <= sum_clamped[SUM_W-1:0];
      last_r <= err_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pid_err) begin
      err_r  <= err_w;
      diff_r <= DIFF_W'(err_w) - DIFF_W'(last_r);
    end
  end

  // PID products, one multiplier each, registered
  logic signed [GAIN_W+ERR_W-1:0]  prod_p_r;
  logic signed [GAIN_W+SUM_W-1:0]  prod_i_r;
  logic signed [GAIN_W+DIFF_W-1:0] prod_d_r;

  always_ff @(posedge clk) begin
    prod_p_r <= (GAIN_W+ERR_W)'(kp_r) * (GAIN_W+ERR_W)'(err_r);
    prod_i_r <= (GAIN_W+SUM_W)'(ki_r) * (GAIN_W+SUM_W)'(sum_r);
    prod_d_r <= (GAIN_W+DIFF_W)'(kd_r) * (GAIN_W+DIFF_W)'(diff_r);
  end

  // Steer and forward drive
  logic signed [STEER_W-1:0] steer_r, pid_sum, turn_steer;
  logic signed [PWM_W-1:0]   fwd_r;
  logic [FX10_W-1:0]         turn_x10;

  assign pid_sum    = STEER_W'(prod_p_r) + STEER_W'(prod_i_r) + STEER_W'(prod_d_r);
  assign turn_x10   = FX10_W'(turn_r) * FX10_W'(10);
  assign turn_steer = $signed(STEER_W'(turn_x10));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_r <= '0;
      fwd_r   <= '0;
    end else if (cmd.steer_en) begin
      case (cmd.steer_sel)
        STEER_PID:      steer_r <= pid_sum;
        STEER_NEG_TURN: steer_r <= -turn_steer;
        STEER_POS_TURN: steer_r <= turn_steer;
        STEER_ZERO:     steer_r <= '0;
        default:        steer_r <= steer_r;
      endcase
      case (cmd.fwd_sel)
        FWD_PID: begin
          if (!stat.line_blocked && err_r == '0) begin
            fwd_r <= $signed({1'b0, cruise_r});
          end else begin
            fwd_r <= '0;
          end
        end
        FWD_ZERO: fwd_r <= '0;
        FWD_BACK: fwd_r <= -$signed({1'b0, turn_r});
        FWD_DASH: fwd_r <= $signed({1'b0, dash_r});
        default:  fwd_r <= fwd_r;
      endcase
    end
  end

  // Wheel stage 1: left/right sums in tenths, steer magnitude
  logic signed [FX10_W-1:0] fwd_x10;
  logic signed [MIX_W-1:0]  mix_l_r, mix_r_r;
  logic [STEER_W-1:0]       s_abs_r;
  logic                     s_neg_r;

  assign fwd_x10 = FX10_W'(fwd_r) * $signed(FX10_W'(10));

  always_ff @(posedge clk) begin
    mix_l_r <= MIX_W'(steer_r) + MIX_W'(fwd_x10);
    mix_r_r <= MIX_W'(steer_r) - MIX_W'(fwd_x10);
    s_abs_r <= steer_r[STEER_W-1] ? STEER_W'(-steer_r) : STEER_W'(steer_r);
    s_neg_r <= steer_r[STEER_W-1];
  end

  // Wheel stage 2: magnitudes and back-wheel numerator
  logic [ABS_W-1:0] l_abs_r, r_abs_r;
  logic [P_W-1:0]   p_r;
  logic             l_neg2_r, r_neg2_r, b_neg2_r;

  always_ff @(posedge clk) begin
    l_abs_r  <= mix_l_r[MIX_W-1] ? ABS_W'(-mix_l_r) : ABS_W'(mix_l_r);
    r_abs_r  <= mix_r_r[MIX_W-1] ? ABS_W'(-mix_r_r) : ABS_W'(mix_r_r);
    l_neg2_r <= mix_l_r[MIX_W-1];
    r_neg2_r <= mix_r_r[MIX_W-1];
    p_r      <= P_W'(s_abs_r) * P_W'(BACK_NUM);
    b_neg2_r <= s_neg_r;
  end

  // Wheel stage 3: saturation tests and reciprocal divides
  logic [PWM_W-1:0]    lim_p1;
  logic [QL_W-1:0]     lim_x10;
  logic [20:0]         lim_x200;
  logic [QL_W+16:0]    ql_prod, qr_prod;
  logic [QB_W+18:0]    qb_prod;
  logic [PWM_W-1:0]    ql_r, qr_r, qb_r;
  logic                l_sat_r, r_sat_r, b_sat_r;
  logic                l_neg3_r, r_neg3_r, b_neg3_r;

  assign lim_p1   = {1'b0, lim_r} + PWM_W'(1);
  assign lim_x10  = QL_W'(lim_p1) * QL_W'(10);
  assign lim_x200 = 21'(lim_p1) * 21'd200;
  assign ql_prod  = (QL_W+17)'(l_abs_r[QL_W-1:0]) * (QL_W+17)'(RECIP_10);
  assign qr_prod  = (QL_W+17)'(r_abs_r[QL_W-1:0]) * (QL_W+17)'(RECIP_10);
  assign qb_prod  = (QB_W+19)'(p_r[QB_W+2:3]) * (QB_W+19)'(RECIP_25);

  always_ff @(posedge clk) begin
    l_sat_r  <= l_abs_r >= ABS_W'(lim_x10);
    r_sat_r  <= r_abs_r >= ABS_W'(lim_x10);
    b_sat_r  <= p_r >= P_W'(lim_x200);
    ql_r     <= ql_prod[RECIP_10_SHIFT +: PWM_W];
    qr_r     <= qr_prod[RECIP_10_SHIFT +: PWM_W];
    qb_r     <= qb_prod[RECIP_25_SHIFT +: PWM_W];
    l_neg3_r <= l_neg2_r;
    r_neg3_r <= r_neg2_r;
    b_neg3_r <= b_neg2_r;
  end

  // Saturated, signed wheel value
  function automatic logic signed [PWM_W-1:0] wheel_value(
    input logic             sat,
    input logic [PWM_W-1:0] quo,
    input logic             neg,
    input logic [DRIVE_W-1:0] lim
  );
    logic [PWM_W-1:0] mag;
    begin
      mag = sat ? {1'b0, lim} : quo;
      wheel_value = neg ? $signed(-mag) : $signed(mag);
    end
  endfunction

  // Avoidance drives, limited to the bound
  logic [DRIVE_W-1:0] turn_sat;
  logic [PWM_W-1:0]   two_turn, back_sat;

  assign turn_sat = (turn_r > lim_r) ? lim_r : turn_r;
  assign two_turn = {turn_r, 1'b0};
  assign back_sat = (two_turn > {1'b0, lim_r}) ? {1'b0, lim_r} : two_turn;

  // Held wheel values double as the result register
  logic signed [PWM_W-1:0] held_l_r, held_r_r, held_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_l_r <= '0;
      held_r_r <= '0;
      held_b_r <= '0;
    end else if (cmd.held_en) begin
      case (cmd.held_sel)
        HELD_MIX: begin
          held_l_r <= wheel_value(l_sat_r, ql_r, l_neg3_r, lim_r);
          held_r_r <= wheel_value(r_sat_r, qr_r, r_neg3_r, lim_r);
          held_b_r <= wheel_value(b_sat_r, qb_r, b_neg3_r, lim_r);
        end
        HELD_AVOID: begin
          held_l_r <= '0;
          held_r_r <= -$signed({1'b0, turn_sat});
          held_b_r <= $signed(back_sat);
        end
        HELD_RETURN: begin
          held_l_r <= -$signed({1'b0, turn_sat});
          held_r_r <= -$signed({1'b0, turn_sat});
          held_b_r <= -$signed({1'b0, turn_sat});
        end
        default: ;
      endcase
    end
  end

  assign pwm_left  = held_l_r;
  assign pwm_right = held_r_r;
  assign pwm_back  = held_b_r;

endmodule

// ----- hdl/line_follow_avoid_controller.sv -----
// Sequence: an accepted request passes through the controller steps in order
//   (decide, PID multiply, steer load, three wheel mixing stages, output); the
//   output step waits only while the previous result is still waiting on
//   out_tready. A new request is accepted only once the controller is idle.
// Reset: synchronous active-low rst_n restores register defaults, line-follow
//   mode, reloaded tick counters and zero wheel drives; no clearing pass.
// ---------------------------------------------------------------------------
// line_follow_avoid_controller
// Per-tick drive controller for a three-wheel line follower with PID
// steering, blocked-line recovery and ultrasonic obstacle avoidance.
// ---------------------------------------------------------------------------
`include "line_follow_avoid_controller_defines.svh"

module line_follow_avoid_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  // sensor_outer_left, sensor_inner_left, sensor_inner_right,
  // sensor_outer_right, distance_cm[15:0], zero pad[3:0]
  input  logic [lfac_pkg::IN_W-1:0]        in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pwm_left[13:0], pwm_right[13:0], pwm_back[13:0], mode_handled[3:0],
  // zero pad[1:0]
  output logic [lfac_pkg::OUT_W-1:0]       out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [lfac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfac_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lfac_pkg::*;

  dp_cmd_t                 cmd;
  dp_stat_t                stat;
  logic [MODE_W-1:0]       out_mode;
  logic signed [PWM_W-1:0] pwm_left, pwm_right, pwm_back;

  // Sequencer
  lfac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_mode   (out_mode),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Arithmetic and configuration
  lfac_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_fields (in_tdata[IN_FIELDS_W-1:0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pwm_left  (pwm_left),
    .pwm_right (pwm_right),
    .pwm_back  (pwm_back)
  );

  // Result packing
  assign out_tdata = {2'b00, out_mode, pwm_back, pwm_right, pwm_left};

  // Checks
  `LFAC_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "request accepted while busy")
  `LFAC_ASSERT_NEXT(a_load_shows, cmd.held_en, out_tvalid, "wheel update not presented")
  `LFAC_ASSERT_SAME(a_rise_from_load, $rose(out_tvalid), $past(cmd.held_en), "result without update")

endmodule
